// ----- rtl/two_key_press_classifier_assert.svh -----
// assertion macros for the two-key press classifier
`ifndef TWO_KEY_PRESS_CLASSIFIER_ASSERT_SVH
`define TWO_KEY_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define TPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpc assertion failed");

// checked also while reset is applied
`define TPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpc assertion failed");

`else

`define TPC_ASSERT(lbl, clk, rst_n, prop)
`define TPC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/tpc_pkg.sv -----
package tpc_pkg;

  localparam int unsigned WINDOW_BITS = 8;
  localparam int unsigned CNT_W       = 8;
  localparam logic [7:0]  LIMIT_RESET = 8'd80;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_K1_SHORT  = 4'd1,
    EV_K2_SHORT  = 4'd2,
    EV_K1_LONG   = 4'd3,
    EV_K2_LONG   = 4'd4,
    EV_BOTH_LONG = 4'd5,
    EV_K1_HELD   = 4'd6,
    EV_K2_HELD   = 4'd7,
    EV_BOTH_HELD = 4'd8
  } event_e;

  typedef struct packed {
    logic pressed_d;
    logic short_ev;
    logic long_ev;
  } key_status_t;

endpackage

// ----- rtl/two_key_press_classifier.sv -----
// Two-key press classifier. Each input item is a tick (tuser 0) that samples the two
// active-low key levels in tdata bits 0 and 1, or a read (tuser 1) that returns one
// event code and clears the one-slot event latch; a tick returns nothing. A key counts
// as pressed while its last 8 samples are all low; windows reset to zero, so a key reads
// as held from its first low sample until a high level is shifted in. A press that lasts more than
// long_press_limit ticks (reset 80, written on the cfg channel) is a long press, an
// earlier release a short press. One item is taken every cycle while the output register
// is empty or m_axis_tready is high: the key state is updated at acceptance and a read
// result goes to an output register and appears in the cycle after the read is accepted.
`include "two_key_press_classifier_assert.svh"

module two_key_press_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] key1_level, [1] key2_level
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] event_code
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic                 in_acc, tick, rd;
  logic [7:0]           limit_q;
  tpc_pkg::event_e      pending_q, pending_d, tick_ev, read_ev;
  tpc_pkg::event_e      out_code_q;
  logic                 out_valid_q;
  tpc_pkg::key_status_t st1, st2;
  logic                 held1, held2, force1, force2;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tick          = in_acc && !s_axis_tuser;
  assign rd            = in_acc && s_axis_tuser;
  assign cfg_ready_o   = 1'b1;

  // a long press on one key drags a held other key into long
  assign force2 = st1.long_ev && !st2.long_ev && !st2.short_ev && st2.pressed_d;
  assign force1 = st2.long_ev && st1.pressed_d;

  tpc_key u_key1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .level_i     (s_axis_tdata[0]),
    .limit_i     (limit_q),
    .force_long_i(force1),
    .status_o    (st1),
    .pressed_o   (held1)
  );

  tpc_key u_key2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .level_i     (s_axis_tdata[1]),
    .limit_i     (limit_q),
    .force_long_i(force2),
    .status_o    (st2),
    .pressed_o   (held2)
  );

  always_comb begin
    if (force1 || force2) begin
      tick_ev = tpc_pkg::EV_BOTH_LONG;
    end else if (st2.long_ev) begin
      tick_ev = tpc_pkg::EV_K2_LONG;
    end else if (st2.short_ev) begin
      tick_ev = tpc_pkg::EV_K2_SHORT;
    end else if (st1.long_ev) begin
      tick_ev = tpc_pkg::EV_K1_LONG;
    end else if (st1.short_ev) begin
      tick_ev = tpc_pkg::EV_K1_SHORT;
    end else begin
      tick_ev = tpc_pkg::EV_NONE;
    end
  end

  always_comb begin
    if (pending_q != tpc_pkg::EV_NONE) begin
      read_ev = pending_q;
    end else if (held1 && held2) begin
      read_ev = tpc_pkg::EV_BOTH_HELD;
    end else if (held2) begin
      read_ev = tpc_pkg::EV_K2_HELD;
    end else if (held1) begin
      read_ev = tpc_pkg::EV_K1_HELD;
    end else begin
      read_ev = tpc_pkg::EV_NONE;
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (rd) begin
      pending_d = tpc_pkg::EV_NONE;
    end else if (tick && (pending_q == tpc_pkg::EV_NONE)) begin
      pending_d = tick_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= tpc_pkg::LIMIT_RESET;
      pending_q   <= tpc_pkg::EV_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      pending_q <= pending_d;
      if (rd) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd) begin
      out_code_q <= read_ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_code_q};

  `TPC_ASSERT(a_pending_holds, clk_i, rst_ni, (pending_q != tpc_pkg::EV_NONE) && !rd |=> pending_q == $past(pending_q))
  `TPC_ASSERT(a_read_gives_result, clk_i, rst_ni, rd |=> m_axis_tvalid && (m_axis_tdata[3:0] == $past(read_ev)))
  `TPC_ASSERT(a_code_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[3:0] <= tpc_pkg::EV_BOTH_HELD)
  `TPC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !m_axis_tvalid && (pending_q == tpc_pkg::EV_NONE))

endmodule

// ----- rtl/tpc_key.sv -----
module tpc_key (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 level_i,
  input  logic [7:0]           limit_i,
  input  logic                 force_long_i,
  output tpc_pkg::key_status_t status_o,
  output logic                 pressed_o
);

  logic [tpc_pkg::WINDOW_BITS-1:0] window_q, window_d;
  logic [tpc_pkg::CNT_W-1:0]       cnt_q, cnt_d, cnt_step;
  logic                            pressed_q, pressed_d;
  logic                            long_q, long_d, long_step;
  logic                            short_ev, long_ev;

  always_comb begin
    window_d  = {window_q[tpc_pkg::WINDOW_BITS-2:0], level_i};
    cnt_step  = cnt_q;
    pressed_d = pressed_q;
    long_step = long_q;
    short_ev  = 1'b0;
    if (window_d == '0) begin
      pressed_d = 1'b1;
      if (!long_q && (cnt_q != tpc_pkg::CNT_MAX)) begin
        cnt_step = cnt_q + 1'b1;
      end
    end else if (pressed_q) begin
      short_ev  = !long_q;
      pressed_d = 1'b0;
      long_step = 1'b0;
      cnt_step  = '0;
    end
    long_ev = (cnt_step > limit_i);
    cnt_d   = cnt_step;
    long_d  = long_step;
    if (long_ev || force_long_i) begin
      long_d = 1'b1;
      cnt_d  = '0;
    end
  end

  assign status_o.pressed_d = pressed_d;
  assign status_o.short_ev  = short_ev;
  assign status_o.long_ev   = long_ev;
  assign pressed_o          = pressed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      cnt_q     <= '0;
      pressed_q <= 1'b0;
      long_q    <= 1'b0;
    end else if (tick_i) begin
      window_q  <= window_d;
      cnt_q     <= cnt_d;
      pressed_q <= pressed_d;
      long_q    <= long_d;
    end
  end

endmodule

// ----- verif/tb_two_key_press_classifier.sv -----
`timescale 1ns / 100ps

module tb_two_key_press_classifier;
  import tpc_pkg::*;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_READ    = 1'b1;
  localparam int   STALL_LIMIT = 1000;

  typedef struct packed {
    logic       cfg_row;
    logic [7:0] limit_val;
    logic       act;
    logic       k1;
    logic       k2;
    logic [3:0] reps;
    logic       known;
    event_e     want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [0] key1_level, [1] key2_level
  logic       s_axis_tuser;   // [0] action
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [3:0] event_code
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  // key model state
  logic [WINDOW_BITS-1:0] key_win [2];
  logic [CNT_W-1:0]       key_hold [2];
  logic                   key_down [2];
  logic                   key_long [2];
  event_e                 latched_ev;
  logic [7:0]             press_limit;

  event_e due_events_q [$];
  event_e row_want;
  logic   row_known;
  event_e next_ev;
  event_e got_want;
  logic   steady;
  logic   moved;
  int     stall_cycles;
  int     mismatch_count;
  int     n_ticks;
  int     n_reads;
  int     n_limits;
  int     code_seen [0:8];

  dir_row_t plan [0:16] = '{
    '{1'b0, 8'd0, ACT_READ, 1'b1, 1'b1, 4'd1, 1'b1, EV_NONE},      // fresh out of reset
    '{1'b0, 8'd0, ACT_TICK, 1'b0, 1'b0, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_READ, 1'b1, 1'b1, 4'd1, 1'b1, EV_BOTH_HELD},
    '{1'b0, 8'd0, ACT_TICK, 1'b1, 1'b1, 4'd1, 1'b0, EV_NONE},      // key 2 short wins
    '{1'b0, 8'd0, ACT_READ, 1'b0, 1'b1, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_READ, 1'b1, 1'b0, 4'd1, 1'b1, EV_NONE},
    '{1'b1, 8'd1, ACT_TICK, 1'b0, 1'b0, 4'd0, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_TICK, 1'b0, 1'b1, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_TICK, 1'b0, 1'b0, 4'd8, 1'b0, EV_NONE},      // key 1 long, key 2 held
    '{1'b0, 8'd0, ACT_TICK, 1'b1, 1'b0, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_READ, 1'b0, 1'b0, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_READ, 1'b1, 1'b1, 4'd1, 1'b1, EV_K2_HELD},
    '{1'b1, 8'd0, ACT_TICK, 1'b0, 1'b0, 4'd0, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_TICK, 1'b1, 1'b1, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_TICK, 1'b0, 1'b1, 4'd8, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_READ, 1'b1, 1'b1, 4'd1, 1'b0, EV_NONE},
    '{1'b0, 8'd0, ACT_READ, 1'b0, 1'b1, 4'd1, 1'b1, EV_K1_HELD}
  };

  two_key_press_classifier DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void sample_key(input int k, input logic lvl, inout event_e ev);
    key_win[k] = {key_win[k][WINDOW_BITS-2:0], lvl};
    if (key_win[k] == '0) begin
      key_down[k] = 1'b1;
      if (!key_long[k] && key_hold[k] != CNT_MAX) key_hold[k] = key_hold[k] + 1'b1;
    end else if (key_down[k]) begin
      if (!key_long[k]) begin
        if (k == 0) ev = EV_K1_SHORT;
        else ev = EV_K2_SHORT;
      end
      key_down[k] = 1'b0;
      key_long[k] = 1'b0;
      key_hold[k] = '0;
    end
    if (key_hold[k] > press_limit) begin
      key_long[k] = 1'b1;
      key_hold[k] = '0;
      if (k == 0) ev = EV_K1_LONG;
      else ev = EV_K2_LONG;
    end
  endfunction

  function automatic void sample_tick(input logic k1, input logic k2);
    event_e ev;
    ev = EV_NONE;
    sample_key(0, k1, ev);
    sample_key(1, k2, ev);
    if (ev == EV_K1_LONG && key_down[1]) begin
      key_long[1] = 1'b1;
      key_hold[1] = '0;
      ev = EV_BOTH_LONG;
    end else if (ev == EV_K2_LONG && key_down[0]) begin
      key_long[0] = 1'b1;
      key_hold[0] = '0;
      ev = EV_BOTH_LONG;
    end
    if (latched_ev == EV_NONE) latched_ev = ev;
  endfunction

  function automatic event_e take_event();
    event_e ev;
    ev = latched_ev;
    latched_ev = EV_NONE;
    if (ev == EV_NONE) begin
      if (key_down[0] && key_down[1]) ev = EV_BOTH_HELD;
      else if (key_down[1]) ev = EV_K2_HELD;
      else if (key_down[0]) ev = EV_K1_HELD;
    end
    return ev;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (due_events_q.size() == 0) begin
          note_mismatch("result with none pending", m_axis_tdata, 8'h00);
        end else begin
          got_want = due_events_q.pop_front();
          code_seen[int'(got_want)]++;
          if (m_axis_tdata !== {4'h0, got_want})
            note_mismatch("event_code", m_axis_tdata, {4'h0, got_want});
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        press_limit = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        if (s_axis_tuser == ACT_READ) begin
          next_ev = take_event();
          due_events_q.push_back(row_known ? row_want : next_ev);
          n_reads++;
        end else begin
          sample_tick(s_axis_tdata[0], s_axis_tdata[1]);
          n_ticks++;
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t no progress, %0d results still pending", $realtime, due_events_q.size());
    $display("** two_key_press_classifier: FAILED **");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      m_axis_tready = steady || ($urandom_range(0, 99) >= 33);
    end
  end

  task automatic push_item(input logic act, input logic k1, input logic k2,
                           input logic known, input event_e want);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {6'b0, k2, k1};
    row_known     = known;
    row_want      = want;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (due_events_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] lim);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = lim;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_limits++;
  endtask

  // runs of steady key levels with bounce and reads mixed in
  task automatic press_episodes(input int n_items, input int max_run);
    int   done;
    int   run;
    logic k1;
    logic k2;
    logic b1;
    logic b2;
    done = 0;
    while (done < n_items) begin
      k1  = ($urandom_range(0, 99) < 60) ? 1'b0 : 1'b1;
      k2  = ($urandom_range(0, 99) < 60) ? 1'b0 : 1'b1;
      run = $urandom_range(1, max_run);
      repeat (run) begin
        b1 = k1;
        b2 = k2;
        if ($urandom_range(0, 99) < 8) begin
          b1 = 1'($urandom_range(0, 1));
          b2 = 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 99) < 20) begin
          push_item(ACT_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'b0, EV_NONE);
          done++;
        end
        push_item(ACT_TICK, b1, b2, 1'b0, EV_NONE);
        done++;
      end
    end
  endtask

  task automatic long_hold(input logic k1, input logic k2, input int ticks);
    repeat (ticks) begin
      if ($urandom_range(0, 99) < 8)
        push_item(ACT_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'b0, EV_NONE);
      push_item(ACT_TICK, k1, k2, 1'b0, EV_NONE);
    end
  endtask

  initial begin
    rst_n          = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ACT_TICK;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    row_known      = 1'b0;
    row_want       = EV_NONE;
    steady         = 1'b0;
    mismatch_count = 0;
    n_ticks        = 0;
    n_reads        = 0;
    n_limits       = 0;
    for (int i = 0; i <= 8; i++) code_seen[i] = 0;
    for (int k = 0; k < 2; k++) begin
      key_win[k]  = '0;
      key_hold[k] = '0;
      key_down[k] = 1'b0;
      key_long[k] = 1'b0;
    end
    latched_ev  = EV_NONE;
    press_limit = LIMIT_RESET;

    // reset edge before the first clock edge
    #1 rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i <= 16; i++) begin
      if (plan[i].cfg_row) set_limit(plan[i].limit_val);
      else begin
        repeat (plan[i].reps)
          push_item(plan[i].act, plan[i].k1, plan[i].k2, plan[i].known, plan[i].want);
      end
    end

    set_limit(8'd2);
    press_episodes(80, 24);

    // long press at the top limit, key 1 ahead of key 2
    set_limit(8'd254);
    steady = 1'b1;
    long_hold(1'b0, 1'b1, 4);
    long_hold(1'b0, 1'b0, 266);
    press_episodes(30, 12);
    steady = 1'b0;

    // counter saturates, no long press
    set_limit(8'd255);
    long_hold(1'b1, 1'b0, 275);
    press_episodes(20, 12);

    set_limit(8'($urandom_range(3, 20)));
    press_episodes(100, 36);

    drain_results();
    repeat (5) @(posedge clk);
    $display("covered %0d key ticks and %0d reads over %0d press limit settings",
             n_ticks, n_reads, n_limits);
    $display("reads returned: none %0d, short %0d, long %0d, both long %0d, held %0d",
             code_seen[0], code_seen[1] + code_seen[2], code_seen[3] + code_seen[4],
             code_seen[5], code_seen[6] + code_seen[7] + code_seen[8]);
    if (mismatch_count == 0) begin
      $display("** two_key_press_classifier: PASSED **");
    end else begin
      $display("** two_key_press_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_key.sv
rtl/two_key_press_classifier.sv
verif/tb_two_key_press_classifier.sv
